// ===== sv/shtd_pkg.sv =====
// ----------------------------------------------------------------------------
// shtd_pkg
// Constants and tree ROM contents for the static Huffman tree decoder.
// ----------------------------------------------------------------------------
package shtd_pkg;

    localparam int NodeW   = 8;
    localparam int EntryW  = 9;   // signed tree entry, -256..255
    localparam int Nodes   = 256;

    localparam logic [0:0] ACT_DECODE = 1'b0;
    localparam logic [0:0] ACT_CLEAR  = 1'b1;

    localparam logic [0:0] KIND_SYMBOL = 1'b0;
    localparam logic [0:0] KIND_HALT   = 1'b1;

    localparam logic signed [EntryW-1:0] HALT_LEAF = -9'sd256;

    typedef logic signed [EntryW-1:0] entry_t;

    // Pair {right, left} of signed 9-bit entries, packed 18 bits.
    typedef logic [2*EntryW-1:0] pair_t;

    function automatic pair_t mk(input int l, input int r);
        logic [EntryW-1:0] lv;
        logic [EntryW-1:0] rv;
        lv = EntryW'(l);
        rv = EntryW'(r);
        return {rv, lv};
    endfunction

    function automatic pair_t tree_rom(input logic [NodeW-1:0] n);
        pair_t p;
        case (n)
            8'd0: p = mk(2,1);     8'd1: p = mk(4,3);     8'd2: p = mk(0,5);
            8'd3: p = mk(7,6);     8'd4: p = mk(9,8);     8'd5: p = mk(11,10);
            8'd6: p = mk(13,12);   8'd7: p = mk(14,-256); 8'd8: p = mk(16,15);
            8'd9: p = mk(18,17);   8'd10: p = mk(20,19);  8'd11: p = mk(22,21);
            8'd12: p = mk(23,-1);  8'd13: p = mk(25,24);  8'd14: p = mk(27,26);
            8'd15: p = mk(29,28);  8'd16: p = mk(31,30);  8'd17: p = mk(33,32);
            8'd18: p = mk(35,34);  8'd19: p = mk(37,36);  8'd20: p = mk(39,38);
            8'd21: p = mk(-64,40); 8'd22: p = mk(42,41);  8'd23: p = mk(44,43);
            8'd24: p = mk(45,-6);  8'd25: p = mk(47,46);  8'd26: p = mk(49,48);
            8'd27: p = mk(51,50);  8'd28: p = mk(52,-119); 8'd29: p = mk(53,-32);
            8'd30: p = mk(-14,54); 8'd31: p = mk(-5,55);  8'd32: p = mk(57,56);
            8'd33: p = mk(59,58);  8'd34: p = mk(-2,60);  8'd35: p = mk(62,61);
            8'd36: p = mk(64,63);  8'd37: p = mk(66,65);  8'd38: p = mk(68,67);
            8'd39: p = mk(70,69);  8'd40: p = mk(72,71);  8'd41: p = mk(73,-51);
            8'd42: p = mk(75,74);  8'd43: p = mk(77,76);  8'd44: p = mk(-111,-101);
            8'd45: p = mk(-97,-4); 8'd46: p = mk(79,78);  8'd47: p = mk(80,-110);
            8'd48: p = mk(-116,81); 8'd49: p = mk(83,82); 8'd50: p = mk(-255,84);
            8'd51: p = mk(86,85);  8'd52: p = mk(88,87);  8'd53: p = mk(90,89);
            8'd54: p = mk(-10,-15); 8'd55: p = mk(92,91); 8'd56: p = mk(93,-21);
            8'd57: p = mk(94,-117); 8'd58: p = mk(96,95); 8'd59: p = mk(98,97);
            8'd60: p = mk(100,99); 8'd61: p = mk(101,-114); 8'd62: p = mk(102,-105);
            8'd63: p = mk(103,-26); 8'd64: p = mk(105,104); 8'd65: p = mk(107,106);
            8'd66: p = mk(109,108); 8'd67: p = mk(111,110); 8'd68: p = mk(-3,112);
            8'd69: p = mk(-7,113); 8'd70: p = mk(-131,114); 8'd71: p = mk(-144,115);
            8'd72: p = mk(117,116); 8'd73: p = mk(118,-20); 8'd74: p = mk(120,119);
            8'd75: p = mk(122,121); 8'd76: p = mk(124,123); 8'd77: p = mk(126,125);
            8'd78: p = mk(128,127); 8'd79: p = mk(-100,129); 8'd80: p = mk(-8,130);
            8'd81: p = mk(132,131); 8'd82: p = mk(134,133); 8'd83: p = mk(135,-120);
            8'd84: p = mk(-31,136); 8'd85: p = mk(138,137); 8'd86: p = mk(-234,-109);
            8'd87: p = mk(140,139); 8'd88: p = mk(142,141); 8'd89: p = mk(144,143);
            8'd90: p = mk(145,-112); 8'd91: p = mk(146,-19); 8'd92: p = mk(148,147);
            8'd93: p = mk(-66,149); 8'd94: p = mk(-145,150); 8'd95: p = mk(-65,-13);
            8'd96: p = mk(152,151); 8'd97: p = mk(154,153); 8'd98: p = mk(155,-30);
            8'd99: p = mk(157,156); 8'd100: p = mk(158,-99); 8'd101: p = mk(160,159);
            8'd102: p = mk(162,161); 8'd103: p = mk(163,-23); 8'd104: p = mk(164,-29);
            8'd105: p = mk(165,-11); 8'd106: p = mk(-115,166); 8'd107: p = mk(168,167);
            8'd108: p = mk(170,169); 8'd109: p = mk(171,-16); 8'd110: p = mk(172,-34);
            8'd111: p = mk(-132,173); 8'd112: p = mk(-108,174); 8'd113: p = mk(-22,175);
            8'd114: p = mk(-9,176); 8'd115: p = mk(-84,177); 8'd116: p = mk(-37,-17);
            8'd117: p = mk(178,-28); 8'd118: p = mk(180,179); 8'd119: p = mk(182,181);
            8'd120: p = mk(184,183); 8'd121: p = mk(186,185); 8'd122: p = mk(-104,187);
            8'd123: p = mk(-78,188); 8'd124: p = mk(-61,189); 8'd125: p = mk(-178,-79);
            8'd126: p = mk(-134,-59); 8'd127: p = mk(-25,190); 8'd128: p = mk(-18,-83);
            8'd129: p = mk(-57,191); 8'd130: p = mk(192,-67); 8'd131: p = mk(193,-98);
            8'd132: p = mk(-68,-12); 8'd133: p = mk(195,194); 8'd134: p = mk(-128,-55);
            8'd135: p = mk(-50,-24); 8'd136: p = mk(196,-70); 8'd137: p = mk(-33,-94);
            8'd138: p = mk(-129,197); 8'd139: p = mk(198,-74); 8'd140: p = mk(199,-82);
            8'd141: p = mk(-87,-56); 8'd142: p = mk(200,-44); 8'd143: p = mk(201,-248);
            8'd144: p = mk(-81,-163); 8'd145: p = mk(-123,-52); 8'd146: p = mk(-113,202);
            8'd147: p = mk(-41,-48); 8'd148: p = mk(-40,-122); 8'd149: p = mk(-90,203);
            8'd150: p = mk(204,-54); 8'd151: p = mk(-192,-86); 8'd152: p = mk(206,205);
            8'd153: p = mk(-130,207); 8'd154: p = mk(208,-53); 8'd155: p = mk(-45,-133);
            8'd156: p = mk(210,209); 8'd157: p = mk(-91,211); 8'd158: p = mk(213,212);
            8'd159: p = mk(-88,-106); 8'd160: p = mk(215,214); 8'd161: p = mk(217,216);
            8'd162: p = mk(-49,218); 8'd163: p = mk(220,219); 8'd164: p = mk(222,221);
            8'd165: p = mk(224,223); 8'd166: p = mk(226,225); 8'd167: p = mk(-102,227);
            8'd168: p = mk(228,-160); 8'd169: p = mk(229,-46); 8'd170: p = mk(230,-127);
            8'd171: p = mk(231,-103); 8'd172: p = mk(233,232); 8'd173: p = mk(234,-60);
            8'd174: p = mk(-76,235); 8'd175: p = mk(-121,236); 8'd176: p = mk(-73,237);
            8'd177: p = mk(238,-149); 8'd178: p = mk(-107,239); 8'd179: p = mk(240,-35);
            8'd180: p = mk(-27,-71); 8'd181: p = mk(241,-69); 8'd182: p = mk(-77,-89);
            8'd183: p = mk(-118,-62); 8'd184: p = mk(-85,-75); 8'd185: p = mk(-58,-72);
            8'd186: p = mk(-80,-63); 8'd187: p = mk(-42,242); 8'd188: p = mk(-157,-150);
            8'd189: p = mk(-236,-139); 8'd190: p = mk(-243,-126); 8'd191: p = mk(-214,-142);
            8'd192: p = mk(-206,-138); 8'd193: p = mk(-146,-240); 8'd194: p = mk(-147,-204);
            8'd195: p = mk(-201,-152); 8'd196: p = mk(-207,-227); 8'd197: p = mk(-209,-154);
            8'd198: p = mk(-254,-153); 8'd199: p = mk(-156,-176); 8'd200: p = mk(-210,-165);
            8'd201: p = mk(-185,-172); 8'd202: p = mk(-170,-195); 8'd203: p = mk(-211,-232);
            8'd204: p = mk(-239,-219); 8'd205: p = mk(-177,-200); 8'd206: p = mk(-212,-175);
            8'd207: p = mk(-143,-244); 8'd208: p = mk(-171,-246); 8'd209: p = mk(-221,-203);
            8'd210: p = mk(-181,-202); 8'd211: p = mk(-250,-173); 8'd212: p = mk(-164,-184);
            8'd213: p = mk(-218,-193); 8'd214: p = mk(-220,-199); 8'd215: p = mk(-249,-190);
            8'd216: p = mk(-217,-230); 8'd217: p = mk(-216,-169); 8'd218: p = mk(-197,-191);
            8'd219: p = mk(243,-47); 8'd220: p = mk(245,244); 8'd221: p = mk(247,246);
            8'd222: p = mk(-159,-148); 8'd223: p = mk(249,248); 8'd224: p = mk(-93,-92);
            8'd225: p = mk(-225,-96); 8'd226: p = mk(-95,-151); 8'd227: p = mk(251,250);
            8'd228: p = mk(252,-241); 8'd229: p = mk(-36,-161); 8'd230: p = mk(254,253);
            8'd231: p = mk(-39,-135); 8'd232: p = mk(-124,-187); 8'd233: p = mk(-251,255);
            8'd234: p = mk(-238,-162); 8'd235: p = mk(-38,-242); 8'd236: p = mk(-125,-43);
            8'd237: p = mk(-253,-215); 8'd238: p = mk(-208,-140); 8'd239: p = mk(-235,-137);
            8'd240: p = mk(-237,-158); 8'd241: p = mk(-205,-136); 8'd242: p = mk(-141,-155);
            8'd243: p = mk(-229,-228); 8'd244: p = mk(-168,-213); 8'd245: p = mk(-194,-224);
            8'd246: p = mk(-226,-196); 8'd247: p = mk(-233,-183); 8'd248: p = mk(-167,-231);
            8'd249: p = mk(-189,-174); 8'd250: p = mk(-166,-252); 8'd251: p = mk(-222,-198);
            8'd252: p = mk(-179,-188); 8'd253: p = mk(-182,-223); 8'd254: p = mk(-186,-180);
            default: p = mk(-247,-245);
        endcase
        return p;
    endfunction

endpackage

// ===== sv/static_huffman_tree_decoder.sv =====
// ----------------------------------------------------------------------------
// static_huffman_tree_decoder
// Walks each compressed byte MSB first through a fixed code tree ROM.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)   | tuser  | tlast
//  s_      | in  | code_byte[7:0]       | action | -
//  m_      | out | symbol[7:0]          | kind   | last
//
// One ROM lookup per bit through a registered ROM read: a decode request is
// accepted, then each bit walked passes a read state and a step state, and a
// flush state follows when the request yields a result; a halt code ends the
// walk early. A clear request only returns the walk node to the root. Walk
// node resets to the root on aresetn low (synchronous). The newest result of
// a byte waits in a pending register until its last flag is known; a leaf
// stalls the walk while both registers are full and the output is not taken.
module static_huffman_tree_decoder
    import shtd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // code_byte[7:0]
    input  logic       s_tuser,   // action
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // symbol[7:0]
    output logic       m_tuser,   // kind
    output logic       m_tlast
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_STEP  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]       state_reg;
    logic [NodeW-1:0] node_reg;
    logic [7:0]       byte_reg;
    logic [2:0]       bit_reg;
    logic             pend_valid_reg;
    logic [0:0]       pend_kind_reg;
    logic [7:0]       pend_sym_reg;
    logic             m_valid_reg;
    logic [7:0]       m_data_reg;
    logic [0:0]       m_kind_reg;
    logic             m_last_reg;
    pair_t            rom_q;
    logic [NodeW-1:0] rom_addr;
    logic             cur_bit;
    entry_t           entry;
    logic             out_free;
    logic             is_leaf;
    logic             step_go;
    logic             push_pend;
    logic             flush_go;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign cur_bit  = byte_reg[bit_reg];
    assign entry    = cur_bit ? entry_t'(rom_q[2*EntryW-1:EntryW])
                              : entry_t'(rom_q[EntryW-1:0]);
    assign rom_addr = node_reg;

    // Step control: a leaf may only replace the pending result once it can move out
    assign is_leaf   = (entry <= 0);
    assign step_go   = (state_reg == ST_STEP) && (!is_leaf || !pend_valid_reg || out_free);
    assign push_pend = (state_reg == ST_STEP) && is_leaf && pend_valid_reg && out_free;
    assign flush_go  = (state_reg == ST_FLUSH) && out_free;

    // Registered ROM read
    always_ff @(posedge aclk) begin
        rom_q <= tree_rom(rom_addr);
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_kind_reg  <= KIND_SYMBOL;
            m_last_reg  <= 1'b0;
        end else if (push_pend || flush_go) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= pend_sym_reg;
            m_kind_reg  <= pend_kind_reg;
            m_last_reg  <= flush_go;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Walk sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_reg       <= '0;
            bit_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_kind_reg  <= KIND_SYMBOL;
            pend_sym_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser == ACT_CLEAR) begin
                            node_reg <= '0;
                        end else begin
                            byte_reg  <= s_tdata;
                            bit_reg   <= 3'd7;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ: state_reg <= ST_STEP;
                ST_STEP: begin
                    if (step_go) begin
                        if (!is_leaf) begin
                            node_reg <= entry[NodeW-1:0];
                            if (bit_reg == 3'd0) begin
                                state_reg <= pend_valid_reg ? ST_FLUSH : ST_IDLE;
                            end else begin
                                bit_reg   <= bit_reg - 3'd1;
                                state_reg <= ST_READ;
                            end
                        end else begin
                            node_reg       <= '0;
                            pend_valid_reg <= 1'b1;
                            if (entry == HALT_LEAF) begin
                                // halt drops the rest of the byte
                                pend_kind_reg <= KIND_HALT;
                                pend_sym_reg  <= '0;
                                state_reg     <= ST_FLUSH;
                            end else begin
                                pend_kind_reg <= KIND_SYMBOL;
                                pend_sym_reg  <= 8'(-entry);
                                if (bit_reg == 3'd0) begin
                                    state_reg <= ST_FLUSH;
                                end else begin
                                    bit_reg   <= bit_reg - 3'd1;
                                    state_reg <= ST_READ;
                                end
                            end
                        end
                    end
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == ST_IDLE)) else $error("ready outside idle");
    a_read_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> (state_reg == ST_STEP)) else $error("no step");
    a_halt_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_HALT) |-> m_tlast) else $error("halt not last");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable({m_tdata, m_tuser, m_tlast})))
        else $error("result changed while stalled");
    a_flush_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) |-> pend_valid_reg) else $error("flush with no result");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the static Huffman tree decoder. Compressed bytes and clear requests
// go in through a queue-fed driver. A local copy of the code tree and walk
// node predicts the decoded symbols and halt results of each request, and a
// monitor compares every result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb
    import shtd_pkg::*;
;

    typedef struct packed {
        logic [0:0] action;
        logic [7:0] code_byte;
    } code_req_t;

    typedef struct packed {
        logic [0:0] kind;
        logic [7:0] symbol;
        logic       last;
    } decoded_t;

    localparam int LongHold  = 300;
    localparam int StallCap  = 5000;
    localparam int TailWait  = 60;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // code_byte[7:0]
    logic       s_tuser;   // action
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // symbol[7:0]
    logic       m_tuser;   // kind
    logic       m_tlast;

    code_req_t  pending_reqs[$];
    decoded_t   expected_syms[$];
    int         tree_code[256][2];
    logic [7:0] model_node;
    int         errors;
    int         idle_cycles;
    bit         calm_phase;
    bit         hold_sink;
    bit         drain_wait;
    bit         s_taken;
    int         src_gap;
    int         sink_gap;
    int         hold_count;

    static_huffman_tree_decoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Tree contents, same values as the code table of the scheme
    initial begin
        int flat[512];
        flat = '{
            2,1,4,3,0,5,7,6,9,8,11,10,13,12,14,-256,16,15,18,17,20,19,22,21,
            23,-1,25,24,27,26,29,28,31,30,33,32,35,34,37,36,39,38,-64,40,42,41,44,43,
            45,-6,47,46,49,48,51,50,52,-119,53,-32,-14,54,-5,55,57,56,59,58,-2,60,62,61,
            64,63,66,65,68,67,70,69,72,71,73,-51,75,74,77,76,-111,-101,-97,-4,79,78,80,-110,
            -116,81,83,82,-255,84,86,85,88,87,90,89,-10,-15,92,91,93,-21,94,-117,96,95,98,97,
            100,99,101,-114,102,-105,103,-26,105,104,107,106,109,108,111,110,-3,112,-7,113,
            -131,114,-144,115,117,116,118,-20,120,119,122,121,124,123,126,125,128,127,
            -100,129,-8,130,132,131,134,133,135,-120,-31,136,138,137,-234,-109,140,139,
            142,141,144,143,145,-112,146,-19,148,147,-66,149,-145,150,-65,-13,152,151,
            154,153,155,-30,157,156,158,-99,160,159,162,161,163,-23,164,-29,165,-11,
            -115,166,168,167,170,169,171,-16,172,-34,-132,173,-108,174,-22,175,-9,176,
            -84,177,-37,-17,178,-28,180,179,182,181,184,183,186,185,-104,187,-78,188,
            -61,189,-178,-79,-134,-59,-25,190,-18,-83,-57,191,192,-67,193,-98,-68,-12,
            195,194,-128,-55,-50,-24,196,-70,-33,-94,-129,197,198,-74,199,-82,-87,-56,
            200,-44,201,-248,-81,-163,-123,-52,-113,202,-41,-48,-40,-122,-90,203,204,-54,
            -192,-86,206,205,-130,207,208,-53,-45,-133,210,209,-91,211,213,212,-88,-106,
            215,214,217,216,-49,218,220,219,222,221,224,223,226,225,-102,227,228,-160,
            229,-46,230,-127,231,-103,233,232,234,-60,-76,235,-121,236,-73,237,238,-149,
            -107,239,240,-35,-27,-71,241,-69,-77,-89,-118,-62,-85,-75,-58,-72,-80,-63,
            -42,242,-157,-150,-236,-139,-243,-126,-214,-142,-206,-138,-146,-240,
            -147,-204,-201,-152,-207,-227,-209,-154,-254,-153,-156,-176,-210,-165,
            -185,-172,-170,-195,-211,-232,-239,-219,-177,-200,-212,-175,-143,-244,
            -171,-246,-221,-203,-181,-202,-250,-173,-164,-184,-218,-193,-220,-199,
            -249,-190,-217,-230,-216,-169,-197,-191,243,-47,245,244,247,246,-159,-148,
            249,248,-93,-92,-225,-96,-95,-151,251,250,252,-241,-36,-161,254,253,
            -39,-135,-124,-187,-251,255,-238,-162,-38,-242,-125,-43,-253,-215,
            -208,-140,-235,-137,-237,-158,-205,-136,-141,-155,-229,-228,-168,-213,
            -194,-224,-226,-196,-233,-183,-167,-231,-189,-174,-166,-252,-222,-198,
            -179,-188,-182,-223,-186,-180,-247,-245
        };
        for (int n = 0; n < 256; n++) begin
            tree_code[n][0] = flat[2*n];
            tree_code[n][1] = flat[2*n+1];
        end
    end

    // Walk one request through the tree and queue the results it yields
    task automatic predict_decode(input code_req_t req);
        decoded_t outs[$];
        decoded_t r;
        int       leaf;
        if (req.action == ACT_CLEAR) begin
            model_node = '0;
            return;
        end
        for (int b = 7; b >= 0; b--) begin
            leaf = tree_code[model_node][req.code_byte[b]];
            if (leaf == -256) begin
                model_node = '0;
                r = '{kind: KIND_HALT, symbol: 8'd0, last: 1'b0};
                outs.push_back(r);
                break;
            end else if (leaf <= 0) begin
                model_node = '0;
                r = '{kind: KIND_SYMBOL, symbol: 8'(-leaf), last: 1'b0};
                outs.push_back(r);
            end else begin
                model_node = 8'(leaf);
            end
        end
        if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
        foreach (outs[k]) expected_syms.push_back(outs[k]);
    endtask

    function automatic code_req_t mk_req(input logic [0:0] act, input logic [7:0] b);
        code_req_t q;
        q.action = act;
        q.code_byte = b;
        return q;
    endfunction

    // Bits of a symbol's codeword, found by searching the tree (at most 11 deep)
    task automatic find_code(input int sym, output logic [15:0] bits, output int len);
        int    node[$];
        logic  [15:0] path[$];
        int    depth[$];
        int    n, d, e;
        logic  [15:0] p;
        len = 0;
        bits = '0;
        node.push_back(0); path.push_back('0); depth.push_back(0);
        while (node.size() > 0) begin
            n = node.pop_front(); p = path.pop_front(); d = depth.pop_front();
            for (int b = 0; b < 2; b++) begin
                e = tree_code[n][b];
                if (e <= 0 && -e == sym) begin
                    bits = (p << 1) | 16'(b);
                    len = d + 1;
                    return;
                end
                if (e > 0) begin
                    node.push_back(e); path.push_back((p << 1) | 16'(b));
                    depth.push_back(d + 1);
                end
            end
        end
    endtask

    // Pack a run of symbols, optionally followed by the halt code, into bytes
    task automatic push_packet(input int nsym, input bit with_halt);
        logic [15:0] cw;
        int          cl;
        logic [7:0]  acc;
        int          fill;
        acc = '0;
        fill = 0;
        for (int s = 0; s <= nsym; s++) begin
            if (s == nsym) begin
                if (!with_halt) break;
                cw = 16'b1101; cl = 4;   // halt codeword
            end else begin
                find_code($urandom_range(0, 255), cw, cl);
            end
            for (int b = cl - 1; b >= 0; b--) begin
                acc = {acc[6:0], cw[b]};
                fill++;
                if (fill == 8) begin
                    pending_reqs.push_back(mk_req(ACT_DECODE, acc));
                    fill = 0;
                end
            end
        end
        if (fill > 0) begin
            acc = acc << (8 - fill);
            acc = acc | 8'($urandom_range(0, 255) >> fill);
            pending_reqs.push_back(mk_req(ACT_DECODE, acc));
        end
    endtask

    // Stimulus: directed corners, a long receiver hold, then packets mixed with noise and clears
    initial begin
        int pick;
        aresetn = 1'b0;
        calm_phase = 1'b0;
        hold_sink = 1'b0;
        drain_wait = 1'b0;
        errors = 0;
        model_node = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        pending_reqs.push_back(mk_req(ACT_DECODE, 8'h00));
        pending_reqs.push_back(mk_req(ACT_DECODE, 8'hFF));
        pending_reqs.push_back(mk_req(ACT_CLEAR,  8'h00));
        pending_reqs.push_back(mk_req(ACT_DECODE, 8'hD0));   // halt, tail dropped
        pending_reqs.push_back(mk_req(ACT_DECODE, 8'h7F));
        pending_reqs.push_back(mk_req(ACT_DECODE, 8'h01));   // codeword left open
        pending_reqs.push_back(mk_req(ACT_DECODE, 8'h55));   // continues it
        pending_reqs.push_back(mk_req(ACT_DECODE, 8'hAA));
        pending_reqs.push_back(mk_req(ACT_DECODE, 8'h03));
        pending_reqs.push_back(mk_req(ACT_CLEAR,  8'hFF));   // clear mid-walk
        pending_reqs.push_back(mk_req(ACT_DECODE, 8'h2C));
        pending_reqs.push_back(mk_req(ACT_CLEAR,  8'h00));
        pending_reqs.push_back(mk_req(ACT_DECODE, 8'hE7));
        pending_reqs.push_back(mk_req(ACT_DECODE, 8'h80));
        push_packet(3, 1'b1);
        pending_reqs.push_back(mk_req(ACT_DECODE, 8'h12));
        pending_reqs.push_back(mk_req(ACT_DECODE, 8'hF0));
        pending_reqs.push_back(mk_req(ACT_DECODE, 8'h0F));

        // Pause until every pending result is out
        wait (pending_reqs.size() == 0 && !s_tvalid);
        drain_wait = 1'b1;
        wait (expected_syms.size() == 0);
        drain_wait = 1'b0;

        // Long receiver hold while the sender keeps offering
        hold_sink = 1'b1;
        push_packet(12, 1'b1);
        wait (hold_sink == 1'b0);

        while (pending_reqs.size() < 380) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) push_packet($urandom_range(1, 8), $urandom_range(0, 3) != 0);
            else if (pick < 9) pending_reqs.push_back(mk_req(ACT_DECODE,
                                                             8'($urandom_range(0, 255))));
            else pending_reqs.push_back(mk_req(ACT_CLEAR, 8'($urandom_range(0, 255))));
        end
        // No idling over the tail of the run
        wait (pending_reqs.size() < 60);
        calm_phase = 1'b1;
        wait (pending_reqs.size() == 0 && !s_tvalid);
        wait (expected_syms.size() == 0);
        repeat (TailWait) @(posedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Input handshake seen at the last rising edge
    always @(posedge aclk) begin
        s_taken <= aresetn && s_tvalid && s_tready;
    end

    // Driver: offers queued requests with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            src_gap  <= 0;
        end else if (s_tvalid && !s_taken) begin
            // hold the request
        end else if (src_gap > 0) begin
            s_tvalid <= 1'b0;
            src_gap  <= src_gap - 1;
        end else if (pending_reqs.size() > 0 && !drain_wait) begin
            code_req_t q;
            q = pending_reqs.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= q.code_byte;
            s_tuser  <= q.action;
            if (!calm_phase && !hold_sink && $urandom_range(0, 5) == 0)
                src_gap <= $urandom_range(1, 9);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver ready: random stall bursts, plus one long hold
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            sink_gap   <= 0;
            hold_count <= 0;
        end else if (hold_sink) begin
            m_tready <= 1'b0;
            if (hold_count == LongHold) begin
                hold_sink  <= 1'b0;
                hold_count <= 0;
            end else begin
                hold_count <= hold_count + 1;
            end
        end else if (sink_gap > 0) begin
            m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else begin
            m_tready <= 1'b1;
            if (!calm_phase && $urandom_range(0, 4) == 0) sink_gap <= $urandom_range(1, 9);
        end
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_decode(mk_req(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                decoded_t got;
                decoded_t want;
                got = '{kind: m_tuser, symbol: m_tdata, last: m_tlast};
                if (expected_syms.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d symbol=%0d last=%0d",
                             $time, got.kind, got.symbol, got.last);
                    errors++;
                end else begin
                    want = expected_syms.pop_front();
                    if (got.kind != want.kind) begin
                        $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                        errors++;
                    end
                    if (got.symbol != want.symbol) begin
                        $display("%0t: symbol expected %0d actual %0d",
                                 $time, want.symbol, got.symbol);
                        errors++;
                    end
                    if (got.last != want.last) begin
                        $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no accepted request or result
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == StallCap) begin
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule
